FILE: rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared field widths, command and status codes, and the transaction structs
// that pass between the stream wrapper and the automaton core.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int CMD_W  = 3;
    localparam int SYM_W  = 5;
    localparam int ANS_W  = 11;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [CMD_W-1:0] command;
    } sac_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ANS_W-1:0]  answer;
    } sac_rsp_t;

endpackage

FILE: rtl/sac_core.sv
// ----------------------------------------------------------------------------
// sac_core
// Suffix automaton sequencer: transition, link, length, order, bucket and
// match stores in synchronous memories, walked by a one-hot state machine.
// ----------------------------------------------------------------------------
module sac_core
    import sac_pkg::*;
#(
    parameter int MAX_TEXT = 1024,
    parameter int ALPHABET = 26
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  sac_req_t req,
    output logic     busy,
    output logic     rsp_valid,
    output sac_rsp_t rsp
);

    localparam int MAX_STATES = 2 * MAX_TEXT;
    localparam int SW         = $clog2(MAX_STATES);
    localparam int LW         = $clog2(MAX_TEXT + 1);
    localparam int TD         = MAX_STATES * ALPHABET;
    localparam int TAW        = $clog2(TD);
    localparam int AIW        = $clog2(ALPHABET + 1);
    localparam int IW         = (SW > AIW) ? SW : AIW;
    localparam logic [SW-1:0] ROOT = SW'(1);
    localparam int NST        = 29;

    typedef enum logic [NST-1:0] {
        ST_IDLE     = NST'(1) << 0,
        ST_INIT     = NST'(1) << 1,
        ST_AP_CLR   = NST'(1) << 2,
        ST_W1_RD    = NST'(1) << 3,
        ST_W1_CHK   = NST'(1) << 4,
        ST_AP_LP    = NST'(1) << 5,
        ST_AP_LQ    = NST'(1) << 6,
        ST_AP_COPY  = NST'(1) << 7,
        ST_W2_RD    = NST'(1) << 8,
        ST_W2_CHK   = NST'(1) << 9,
        ST_FN_CLRB  = NST'(1) << 10,
        ST_FN_CNT_A = NST'(1) << 11,
        ST_FN_CNT_B = NST'(1) << 12,
        ST_FN_CNT_C = NST'(1) << 13,
        ST_FN_PFX_R = NST'(1) << 14,
        ST_FN_PFX_W = NST'(1) << 15,
        ST_FN_PL_A  = NST'(1) << 16,
        ST_FN_PL_B  = NST'(1) << 17,
        ST_FN_PL_C  = NST'(1) << 18,
        ST_Q_RD     = NST'(1) << 19,
        ST_Q_CHK    = NST'(1) << 20,
        ST_Q_LEN    = NST'(1) << 21,
        ST_Q_UPD    = NST'(1) << 22,
        ST_E1_A     = NST'(1) << 23,
        ST_E1_B     = NST'(1) << 24,
        ST_E1_C     = NST'(1) << 25,
        ST_E1_D     = NST'(1) << 26,
        ST_E2_RD    = NST'(1) << 27,
        ST_E2_WR    = NST'(1) << 28
    } sac_state_t;

    function automatic logic [TAW-1:0] tr_addr(input logic [TAW-1:0] s,
                                               input logic [TAW-1:0] k);
        return s * TAW'(ALPHABET) + k;
    endfunction

    // memories
    logic [SW-1:0] tr_mem [TD];
    logic [SW-1:0] lk_mem [MAX_STATES];
    logic [LW-1:0] ln_mem [MAX_STATES];
    logic [SW-1:0] od_mem [MAX_STATES];
    logic [SW-1:0] bk_mem [MAX_TEXT+1];
    logic [LW-1:0] qb_mem [MAX_STATES];
    logic [LW-1:0] cb_mem [MAX_STATES];

    logic [TAW-1:0] tr_ra, tr_wa;
    logic [SW-1:0]  tr_wd, tr_rd;
    logic           tr_we;
    logic [SW-1:0]  lk_ra, lk_wa, lk_wd, lk_rd;
    logic           lk_we;
    logic [SW-1:0]  ln_ra, ln_wa;
    logic [LW-1:0]  ln_wd, ln_rd;
    logic           ln_we;
    logic [SW-1:0]  od_ra, od_wa, od_wd, od_rd;
    logic           od_we;
    logic [LW-1:0]  bk_ra, bk_wa;
    logic [SW-1:0]  bk_wd, bk_rd;
    logic           bk_we;
    logic [SW-1:0]  qb_ra, qb_wa;
    logic [LW-1:0]  qb_wd, qb_rd;
    logic           qb_we;
    logic [SW-1:0]  cb_ra, cb_wa;
    logic [LW-1:0]  cb_wd, cb_rd;
    logic           cb_we;

    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            tr_mem[tr_wa] <= tr_wd;
        end
        tr_rd <= tr_mem[tr_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            lk_mem[lk_wa] <= lk_wd;
        end
        lk_rd <= lk_mem[lk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ln_we)
        begin
            ln_mem[ln_wa] <= ln_wd;
        end
        ln_rd <= ln_mem[ln_ra];
    end

    always_ff @(posedge clk)
    begin
        if (od_we)
        begin
            od_mem[od_wa] <= od_wd;
        end
        od_rd <= od_mem[od_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bk_we)
        begin
            bk_mem[bk_wa] <= bk_wd;
        end
        bk_rd <= bk_mem[bk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (qb_we)
        begin
            qb_mem[qb_wa] <= qb_wd;
        end
        qb_rd <= qb_mem[qb_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cb_we)
        begin
            cb_mem[cb_wa] <= cb_wd;
        end
        cb_rd <= cb_mem[cb_ra];
    end

    // control and work registers
    sac_state_t       state_reg, state_next;
    logic [SW-1:0]    last_reg, last_next;
    logic [SW-1:0]    count_reg, count_next;
    logic [SW-1:0]    walk_reg, walk_next;
    logic [SW-1:0]    p_reg, p_next;
    logic [SW-1:0]    cur_reg, cur_next;
    logic [SW-1:0]    q_reg, q_next;
    logic [SW-1:0]    cl_reg, cl_next;
    logic [SW-1:0]    up_reg, up_next;
    logic [SW-1:0]    sum_reg, sum_next;
    logic [LW-1:0]    tlen_reg, tlen_next;
    logic [LW-1:0]    mlen_reg, mlen_next;
    logic [LW-1:0]    best_reg, best_next;
    logic [LW-1:0]    lenp_reg, lenp_next;
    logic [LW-1:0]    lenv_reg, lenv_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [SYM_W-1:0] c_reg, c_next;
    logic             fin_reg, fin_next;
    logic             clrp_reg, clrp_next;

    logic           sym_ok;
    logic           store_full;
    logic [LW:0]    mp1;
    logic [LW-1:0]  q_len;
    logic [LW-1:0]  min_best;
    logic [SW-1:0]  pfx_sum;
    logic [TAW-1:0] p_c_addr;
    logic           idx_last_sym;
    logic           idx_is_count;
    logic           idx_is_tlen;

    assign sym_ok       = 32'(req.symbol) < ALPHABET;
    assign store_full   = (32'(tlen_reg) >= MAX_TEXT) || (32'(count_reg) > MAX_STATES - 3);
    assign mp1          = (LW+1)'(mlen_reg) + (LW+1)'(1);
    assign q_len        = (mp1 > (LW+1)'(ln_rd)) ? ln_rd : mp1[LW-1:0];
    assign min_best     = (qb_rd < cb_rd) ? qb_rd : cb_rd;
    assign pfx_sum      = bk_rd + ((idx_reg == '0) ? '0 : sum_reg);
    assign p_c_addr     = tr_addr(TAW'(p_reg), TAW'(c_reg));
    assign idx_last_sym = idx_reg == IW'(ALPHABET - 1);
    assign idx_is_count = idx_reg == IW'(count_reg);
    assign idx_is_tlen  = idx_reg == IW'(tlen_reg);
    assign busy         = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        count_next = count_reg;
        walk_next  = walk_reg;
        p_next     = p_reg;
        cur_next   = cur_reg;
        q_next     = q_reg;
        cl_next    = cl_reg;
        up_next    = up_reg;
        sum_next   = sum_reg;
        tlen_next  = tlen_reg;
        mlen_next  = mlen_reg;
        best_next  = best_reg;
        lenp_next  = lenp_reg;
        lenv_next  = lenv_reg;
        idx_next   = idx_reg;
        c_next     = c_reg;
        fin_next   = fin_reg;
        clrp_next  = clrp_reg;
        rsp_valid  = 1'b0;
        rsp        = '0;
        tr_ra = '0; tr_we = 1'b0; tr_wa = '0; tr_wd = '0;
        lk_ra = '0; lk_we = 1'b0; lk_wa = '0; lk_wd = '0;
        ln_ra = '0; ln_we = 1'b0; ln_wa = '0; ln_wd = '0;
        od_ra = '0; od_we = 1'b0; od_wa = '0; od_wd = '0;
        bk_ra = '0; bk_we = 1'b0; bk_wa = '0; bk_wd = '0;
        qb_ra = '0; qb_we = 1'b0; qb_wa = '0; qb_wd = '0;
        cb_ra = '0; cb_we = 1'b0; cb_wa = '0; cb_wd = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    c_next = req.symbol;
                    case (req.command)
                        CMD_CLEAR:
                        begin
                            count_next = ROOT;
                            last_next  = ROOT;
                            walk_next  = ROOT;
                            tlen_next  = '0;
                            mlen_next  = '0;
                            best_next  = '0;
                            fin_next   = 1'b0;
                            idx_next   = '0;
                            clrp_next  = 1'b1;
                            state_next = ST_INIT;
                        end
                        CMD_APPEND:
                        begin
                            if (fin_reg || !sym_ok)
                            begin
                                rsp_valid  = 1'b1;
                                rsp.status = STAT_BAD;
                            end
                            else if (store_full)
                            begin
                                rsp_valid  = 1'b1;
                                rsp.status = STAT_FULL;
                            end
                            else
                            begin
                                cur_next   = count_reg + SW'(1);
                                count_next = count_reg + SW'(1);
                                idx_next   = '0;
                                state_next = ST_AP_CLR;
                            end
                        end
                        CMD_FINISH:
                        begin
                            if (fin_reg)
                            begin
                                rsp_valid  = 1'b1;
                                rsp.status = STAT_BAD;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_FN_CLRB;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (!fin_reg)
                            begin
                                rsp_valid  = 1'b1;
                                rsp.status = STAT_BAD;
                            end
                            else if (!sym_ok)
                            begin
                                walk_next  = ROOT;
                                mlen_next  = '0;
                                rsp_valid  = 1'b1;
                                rsp.status = STAT_OK;
                            end
                            else
                            begin
                                p_next     = walk_reg;
                                state_next = ST_Q_RD;
                            end
                        end
                        CMD_END:
                        begin
                            if (!fin_reg)
                            begin
                                rsp_valid  = 1'b1;
                                rsp.status = STAT_BAD;
                            end
                            else
                            begin
                                idx_next   = IW'(count_reg);
                                state_next = ST_E1_A;
                            end
                        end
                        CMD_READ:
                        begin
                            rsp_valid = 1'b1;
                            if (!fin_reg)
                            begin
                                rsp.status = STAT_BAD;
                            end
                            else
                            begin
                                rsp.answer = ANS_W'(best_reg);
                            end
                        end
                        default:
                        begin
                            rsp_valid  = 1'b1;
                            rsp.status = STAT_BAD;
                        end
                    endcase
                end
            end

            // root row, length and link cleared
            ST_INIT:
            begin
                tr_we = 1'b1;
                tr_wa = tr_addr(TAW'(ROOT), TAW'(idx_reg));
                if (idx_reg == '0)
                begin
                    ln_we = 1'b1;
                    ln_wa = ROOT;
                    lk_we = 1'b1;
                    lk_wa = ROOT;
                end
                idx_next = idx_reg + IW'(1);
                if (idx_last_sym)
                begin
                    state_next = ST_IDLE;
                    rsp_valid  = clrp_reg;
                    clrp_next  = 1'b0;
                end
            end

            ST_AP_CLR:
            begin
                tr_we = 1'b1;
                tr_wa = tr_addr(TAW'(cur_reg), TAW'(idx_reg));
                if (idx_reg == '0)
                begin
                    ln_we = 1'b1;
                    ln_wa = cur_reg;
                    ln_wd = tlen_reg + LW'(1);
                end
                idx_next = idx_reg + IW'(1);
                if (idx_last_sym)
                begin
                    p_next     = last_reg;
                    state_next = ST_W1_RD;
                end
            end

            ST_W1_RD:
            begin
                if (p_reg == '0)
                begin
                    lk_we      = 1'b1;
                    lk_wa      = cur_reg;
                    lk_wd      = ROOT;
                    last_next  = cur_reg;
                    tlen_next  = tlen_reg + LW'(1);
                    rsp_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    tr_ra      = p_c_addr;
                    lk_ra      = p_reg;
                    state_next = ST_W1_CHK;
                end
            end

            ST_W1_CHK:
            begin
                if (tr_rd == '0)
                begin
                    tr_we      = 1'b1;
                    tr_wa      = p_c_addr;
                    tr_wd      = cur_reg;
                    p_next     = lk_rd;
                    state_next = ST_W1_RD;
                end
                else
                begin
                    q_next     = tr_rd;
                    ln_ra      = p_reg;
                    state_next = ST_AP_LP;
                end
            end

            ST_AP_LP:
            begin
                lenp_next  = ln_rd;
                ln_ra      = q_reg;
                lk_ra      = q_reg;
                state_next = ST_AP_LQ;
            end

            ST_AP_LQ:
            begin
                if (ln_rd == lenp_reg + LW'(1))
                begin
                    lk_we      = 1'b1;
                    lk_wa      = cur_reg;
                    lk_wd      = q_reg;
                    last_next  = cur_reg;
                    tlen_next  = tlen_reg + LW'(1);
                    rsp_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cl_next    = count_reg + SW'(1);
                    count_next = count_reg + SW'(1);
                    ln_we      = 1'b1;
                    ln_wa      = count_reg + SW'(1);
                    ln_wd      = lenp_reg + LW'(1);
                    lk_we      = 1'b1;
                    lk_wa      = count_reg + SW'(1);
                    lk_wd      = lk_rd;
                    idx_next   = '0;
                    state_next = ST_AP_COPY;
                end
            end

            // clone row copy, one read ahead of the write
            ST_AP_COPY:
            begin
                tr_ra = tr_addr(TAW'(q_reg), TAW'(idx_reg));
                if (idx_reg != '0)
                begin
                    tr_we = 1'b1;
                    tr_wa = tr_addr(TAW'(cl_reg), TAW'(idx_reg - IW'(1)));
                    tr_wd = tr_rd;
                end
                if (idx_reg == '0)
                begin
                    lk_we = 1'b1;
                    lk_wa = q_reg;
                    lk_wd = cl_reg;
                end
                else if (idx_reg == IW'(1))
                begin
                    lk_we = 1'b1;
                    lk_wa = cur_reg;
                    lk_wd = cl_reg;
                end
                if (idx_reg == IW'(ALPHABET))
                begin
                    state_next = ST_W2_RD;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            ST_W2_RD:
            begin
                if (p_reg == '0)
                begin
                    last_next  = cur_reg;
                    tlen_next  = tlen_reg + LW'(1);
                    rsp_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    tr_ra      = p_c_addr;
                    lk_ra      = p_reg;
                    state_next = ST_W2_CHK;
                end
            end

            ST_W2_CHK:
            begin
                if (tr_rd == q_reg)
                begin
                    tr_we      = 1'b1;
                    tr_wa      = p_c_addr;
                    tr_wd      = cl_reg;
                    p_next     = lk_rd;
                    state_next = ST_W2_RD;
                end
                else
                begin
                    last_next  = cur_reg;
                    tlen_next  = tlen_reg + LW'(1);
                    rsp_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FN_CLRB:
            begin
                bk_we = 1'b1;
                bk_wa = idx_reg[LW-1:0];
                if (idx_is_tlen)
                begin
                    idx_next   = IW'(1);
                    state_next = ST_FN_CNT_A;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            ST_FN_CNT_A:
            begin
                ln_ra      = idx_reg[SW-1:0];
                state_next = ST_FN_CNT_B;
            end

            ST_FN_CNT_B:
            begin
                lenv_next  = ln_rd;
                bk_ra      = ln_rd;
                cb_we      = 1'b1;
                cb_wa      = idx_reg[SW-1:0];
                cb_wd      = ln_rd;
                qb_we      = 1'b1;
                qb_wa      = idx_reg[SW-1:0];
                state_next = ST_FN_CNT_C;
            end

            ST_FN_CNT_C:
            begin
                bk_we = 1'b1;
                bk_wa = lenv_reg;
                bk_wd = bk_rd + SW'(1);
                if (idx_is_count)
                begin
                    idx_next   = '0;
                    state_next = ST_FN_PFX_R;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_FN_CNT_A;
                end
            end

            ST_FN_PFX_R:
            begin
                bk_ra      = idx_reg[LW-1:0];
                state_next = ST_FN_PFX_W;
            end

            ST_FN_PFX_W:
            begin
                bk_we    = 1'b1;
                bk_wa    = idx_reg[LW-1:0];
                bk_wd    = pfx_sum;
                sum_next = pfx_sum;
                if (idx_is_tlen)
                begin
                    idx_next   = IW'(1);
                    state_next = ST_FN_PL_A;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_FN_PFX_R;
                end
            end

            ST_FN_PL_A:
            begin
                ln_ra      = idx_reg[SW-1:0];
                state_next = ST_FN_PL_B;
            end

            ST_FN_PL_B:
            begin
                lenv_next  = ln_rd;
                bk_ra      = ln_rd;
                state_next = ST_FN_PL_C;
            end

            ST_FN_PL_C:
            begin
                bk_we = 1'b1;
                bk_wa = lenv_reg;
                bk_wd = bk_rd - SW'(1);
                od_we = 1'b1;
                od_wa = bk_rd - SW'(1);
                od_wd = idx_reg[SW-1:0];
                if (idx_is_count)
                begin
                    fin_next   = 1'b1;
                    walk_next  = ROOT;
                    mlen_next  = '0;
                    best_next  = tlen_reg;
                    rsp_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_FN_PL_A;
                end
            end

            ST_Q_RD:
            begin
                tr_ra      = p_c_addr;
                lk_ra      = p_reg;
                state_next = ST_Q_CHK;
            end

            ST_Q_CHK:
            begin
                if (tr_rd != '0)
                begin
                    q_next     = tr_rd;
                    ln_ra      = tr_rd;
                    qb_ra      = tr_rd;
                    state_next = ST_Q_UPD;
                end
                else if (p_reg != ROOT)
                begin
                    p_next     = lk_rd;
                    ln_ra      = lk_rd;
                    state_next = ST_Q_LEN;
                end
                else
                begin
                    mlen_next  = '0;
                    walk_next  = p_reg;
                    rsp_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_Q_LEN:
            begin
                mlen_next  = ln_rd;
                state_next = ST_Q_RD;
            end

            ST_Q_UPD:
            begin
                if (qb_rd < q_len)
                begin
                    qb_we = 1'b1;
                    qb_wa = q_reg;
                    qb_wd = q_len;
                end
                mlen_next  = q_len;
                walk_next  = q_reg;
                rsp_valid  = 1'b1;
                state_next = ST_IDLE;
            end

            // longest states first, matches pushed up the links
            ST_E1_A:
            begin
                if (idx_reg == '0)
                begin
                    idx_next   = IW'(1);
                    best_next  = '0;
                    state_next = ST_E2_RD;
                end
                else
                begin
                    od_ra      = SW'(idx_reg - IW'(1));
                    state_next = ST_E1_B;
                end
            end

            ST_E1_B:
            begin
                qb_ra      = od_rd;
                lk_ra      = od_rd;
                state_next = ST_E1_C;
            end

            ST_E1_C:
            begin
                if (qb_rd != '0 && lk_rd != '0)
                begin
                    up_next    = lk_rd;
                    ln_ra      = lk_rd;
                    state_next = ST_E1_D;
                end
                else
                begin
                    idx_next   = idx_reg - IW'(1);
                    state_next = ST_E1_A;
                end
            end

            ST_E1_D:
            begin
                qb_we      = 1'b1;
                qb_wa      = up_reg;
                qb_wd      = ln_rd;
                idx_next   = idx_reg - IW'(1);
                state_next = ST_E1_A;
            end

            ST_E2_RD:
            begin
                qb_ra      = idx_reg[SW-1:0];
                cb_ra      = idx_reg[SW-1:0];
                state_next = ST_E2_WR;
            end

            ST_E2_WR:
            begin
                cb_we = 1'b1;
                cb_wa = idx_reg[SW-1:0];
                cb_wd = min_best;
                qb_we = 1'b1;
                qb_wa = idx_reg[SW-1:0];
                if (min_best > best_reg)
                begin
                    best_next = min_best;
                end
                if (idx_is_count)
                begin
                    walk_next  = ROOT;
                    mlen_next  = '0;
                    rsp_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_E2_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            last_reg  <= ROOT;
            count_reg <= ROOT;
            walk_reg  <= ROOT;
            tlen_reg  <= '0;
            mlen_reg  <= '0;
            best_reg  <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            clrp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            tlen_reg  <= tlen_next;
            mlen_reg  <= mlen_next;
            best_reg  <= best_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            clrp_reg  <= clrp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        cur_reg  <= cur_next;
        q_reg    <= q_next;
        cl_reg   <= cl_next;
        up_reg   <= up_next;
        sum_reg  <= sum_next;
        lenp_reg <= lenp_next;
        lenv_reg <= lenv_next;
        c_reg    <= c_next;
    end

endmodule

FILE: rtl/suffix_automaton_common_substring.sv
// ----------------------------------------------------------------------------
// suffix_automaton_common_substring
// Stream wrapper around the suffix automaton core: input acceptance and the
// registered result stage.
//
//   channel   dir  bits  contents
//   s_axis    in   8     command [2:0], symbol [7:3]
//   m_axis    out  16    answer [10:0], status [12:11], zero [15:13]
//
// one transaction in flight; read and rejected commands are answered from idle
// append: row clear, then a link walk that ends at the root or on a hit;
//   a clone adds a row copy, a walk over the redirected links and a close
// finish: bucket clear, length count, prefix sum, then placement by length
// query symbol: a walk up the links to a hit or the root; end query: push-up, then merge
// after reset, the root row is cleared before the first command; clear also clears it
// results wait in the output register; input stalls until it can be freed
// ----------------------------------------------------------------------------
module suffix_automaton_common_substring
    import sac_pkg::*;
#(
    parameter int MAX_TEXT = 1024,
    parameter int ALPHABET = 26
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // command, symbol
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // answer, status, zero pad
);

    logic     core_busy;
    logic     rsp_valid;
    sac_rsp_t rsp;
    sac_req_t req;
    logic     accept;

    logic     out_valid_reg, out_valid_next;
    sac_rsp_t out_data_reg, out_data_next;

    assign req           = sac_req_t'(s_axis_tdata);
    assign s_axis_tready = !core_busy && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    sac_core #(
        .MAX_TEXT (MAX_TEXT),
        .ALPHABET (ALPHABET)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (accept),
        .req       (req),
        .busy      (core_busy),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (rsp_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rsp;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg};

endmodule

FILE: rtl/sac_checker.sv
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks for the suffix automaton block, bound to the top level.
// ----------------------------------------------------------------------------
module sac_checker
    import sac_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata))
        else $error("unknown input transaction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12:11] == STAT_OK ||
                           m_axis_tdata[12:11] == STAT_FULL ||
                           m_axis_tdata[12:11] == STAT_BAD))
        else $error("bad status code");

    a_answer_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[10:0] != '0 |-> m_axis_tdata[12:11] == STAT_OK)
        else $error("answer with error status");

endmodule

bind suffix_automaton_common_substring sac_checker u_sac_checker (.*);

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for suffix_automaton_common_substring. Command
// transactions go in on s_axis. A built-in copy of the suffix automaton
// (build, counting sort, query walk, end-of-query merge, read) predicts
// answer and status for each one. Each m_axis result is checked against the
// oldest prediction. Both sides idle at random, and the receiver also holds
// off for long stretches.
// ----------------------------------------------------------------------------
module tb;
    import sac_pkg::*;

    localparam int TEXT_MAX  = 1024;
    localparam int SYMBOLS   = 26;
    localparam int STATE_MAX = 2 * TEXT_MAX;
    localparam int ROOT      = 1;
    localparam int LIMIT     = 4000000;
    localparam int HOLD_LEN  = 400;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    suffix_automaton_common_substring uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // automaton copy
    int        edge_to [0:STATE_MAX*SYMBOLS-1];
    int        link_of [0:STATE_MAX-1];
    int        len_of [0:STATE_MAX-1];
    int        by_len [0:STATE_MAX-1];
    int        bucket [0:TEXT_MAX];
    int        walk_best [0:STATE_MAX-1];
    int        common_len [0:STATE_MAX-1];
    int        last_st;
    int        n_states;
    int        text_len;
    int        walk_st;
    int        walk_len;
    bit        built;

    sac_rsp_t  pending_q[$];
    int        errors;
    int        cycles;
    int        rx_hold;
    bit        hold_req;
    bit        hold_seen;
    bit        no_idle;

    function automatic void sam_clear();
        for (int a = 0; a < SYMBOLS; a++)
            edge_to[ROOT*SYMBOLS + a] = 0;
        link_of[ROOT] = 0;
        len_of[ROOT] = 0;
        last_st = ROOT;
        n_states = ROOT;
        text_len = 0;
        walk_st = ROOT;
        walk_len = 0;
        built = 1'b0;
    endfunction

    function automatic int sam_new_state();
        n_states++;
        for (int a = 0; a < SYMBOLS; a++)
            edge_to[n_states*SYMBOLS + a] = 0;
        link_of[n_states] = 0;
        len_of[n_states] = 0;
        return n_states;
    endfunction

    function automatic void sam_extend(int c);
        int cur;
        int p;
        int q;
        int cl;
        cur = sam_new_state();
        p = last_st;
        len_of[cur] = len_of[p] + 1;
        while (p != 0 && edge_to[p*SYMBOLS + c] == 0) begin
            edge_to[p*SYMBOLS + c] = cur;
            p = link_of[p];
        end
        if (p == 0) begin
            link_of[cur] = ROOT;
        end
        else begin
            q = edge_to[p*SYMBOLS + c];
            if (len_of[q] == len_of[p] + 1) begin
                link_of[cur] = q;
            end
            else begin
                cl = sam_new_state();
                len_of[cl] = len_of[p] + 1;
                for (int a = 0; a < SYMBOLS; a++)
                    edge_to[cl*SYMBOLS + a] = edge_to[q*SYMBOLS + a];
                link_of[cl] = link_of[q];
                link_of[q] = cl;
                link_of[cur] = cl;
                while (p != 0 && edge_to[p*SYMBOLS + c] == q) begin
                    edge_to[p*SYMBOLS + c] = cl;
                    p = link_of[p];
                end
            end
        end
        last_st = cur;
        text_len++;
    endfunction

    function automatic void sam_finish();
        for (int i = 0; i <= TEXT_MAX; i++)
            bucket[i] = 0;
        for (int v = 1; v <= n_states; v++)
            bucket[len_of[v]]++;
        for (int i = 1; i <= text_len; i++)
            bucket[i] += bucket[i-1];
        for (int v = 1; v <= n_states; v++) begin
            bucket[len_of[v]]--;
            by_len[bucket[len_of[v]]] = v;
        end
        for (int v = 1; v <= n_states; v++) begin
            common_len[v] = len_of[v];
            walk_best[v] = 0;
        end
        walk_st = ROOT;
        walk_len = 0;
        built = 1'b1;
    endfunction

    function automatic void sam_walk(int c);
        int p;
        p = walk_st;
        if (c >= SYMBOLS) begin
            walk_st = ROOT;
            walk_len = 0;
            return;
        end
        while (p != ROOT && edge_to[p*SYMBOLS + c] == 0) begin
            p = link_of[p];
            walk_len = len_of[p];
        end
        if (edge_to[p*SYMBOLS + c] != 0) begin
            p = edge_to[p*SYMBOLS + c];
            walk_len++;
            if (walk_len > len_of[p])
                walk_len = len_of[p];
            if (walk_best[p] < walk_len)
                walk_best[p] = walk_len;
        end
        else begin
            walk_len = 0;
        end
        walk_st = p;
    endfunction

    function automatic void sam_merge();
        int v;
        for (int i = n_states; i > 0; i--) begin
            v = by_len[i-1];
            if (walk_best[v] != 0 && link_of[v] != 0)
                walk_best[link_of[v]] = len_of[link_of[v]];
        end
        for (int w = 1; w <= n_states; w++) begin
            if (walk_best[w] < common_len[w])
                common_len[w] = walk_best[w];
            walk_best[w] = 0;
        end
        walk_st = ROOT;
        walk_len = 0;
    endfunction

    function automatic sac_rsp_t sam_step(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym);
        sac_rsp_t r;
        int       best;
        r.answer = '0;
        r.status = STAT_OK;
        best = 0;
        case (cmd)
            CMD_CLEAR:  sam_clear();
            CMD_APPEND: begin
                if (built || int'(sym) >= SYMBOLS)
                    r.status = STAT_BAD;
                else if (text_len >= TEXT_MAX || n_states > STATE_MAX - 3)
                    r.status = STAT_FULL;
                else
                    sam_extend(int'(sym));
            end
            CMD_FINISH: begin
                if (built)
                    r.status = STAT_BAD;
                else
                    sam_finish();
            end
            CMD_QUERY: begin
                if (!built)
                    r.status = STAT_BAD;
                else
                    sam_walk(int'(sym));
            end
            CMD_END: begin
                if (!built)
                    r.status = STAT_BAD;
                else
                    sam_merge();
            end
            CMD_READ: begin
                if (!built)
                    r.status = STAT_BAD;
                else begin
                    for (int v = 1; v <= n_states; v++)
                        if (common_len[v] > best)
                            best = common_len[v];
                    r.answer = ANS_W'(best);
                end
            end
            default: r.status = STAT_BAD;
        endcase
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver with random stalls and long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            rx_hold <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 8);
        end
    end

    // result check
    always @(posedge clk)
    begin
        sac_rsp_t want;
        sac_rsp_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[12:0];
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: answer %0d status %0d",
                             got.answer, got.status);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.answer !== want.answer || got.status !== want.status
                    || m_axis_tdata[15:13] !== 3'b000)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected answer %0d status %0d, got %0d %0d (%h)",
                                 want.answer, want.status, got.answer, got.status,
                                 m_axis_tdata);
                end
            end
        end
    end

    task automatic send(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym);
        if (!no_idle && $urandom_range(0, 99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {sym, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_q.push_back(sam_step(cmd, sym));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send(CMD_READ, 5'd0);
        send(CMD_QUERY, 5'd1);
        send(CMD_END, 5'd0);
        send(3'd6, 5'd31);
        send(3'd7, 5'd10);
        send(CMD_APPEND, 5'd26);
        send(CMD_APPEND, 5'd31);
        send(CMD_APPEND, 5'd0);
        send(CMD_APPEND, 5'd1);
        send(CMD_APPEND, 5'd0);
        send(CMD_APPEND, 5'd1);
        send(CMD_APPEND, 5'd25);
        send(CMD_FINISH, 5'd0);
        send(CMD_READ, 5'd0);
        send(CMD_FINISH, 5'd0);
        send(CMD_APPEND, 5'd2);
        send(CMD_QUERY, 5'd31);
        send(CMD_QUERY, 5'd1);
        send(CMD_QUERY, 5'd0);
        send(CMD_QUERY, 5'd1);
        send(CMD_END, 5'd0);
        send(CMD_END, 5'd0);
        send(CMD_READ, 5'd0);
        send(CMD_CLEAR, 5'd0);
        drain();
    endtask

    task automatic test_capacity();
        send(CMD_CLEAR, 5'd0);
        for (int i = 0; i < TEXT_MAX + 6; i++)
            send(CMD_APPEND, (i % 7 == 3) ? 5'($urandom_range(0, 25)) : 5'($urandom_range(0, 1)));
        send(CMD_FINISH, 5'd0);
        for (int i = 0; i < 12; i++)
            send(CMD_QUERY, 5'($urandom_range(0, 1)));
        send(CMD_END, 5'd0);
        send(CMD_READ, 5'd0);
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = ~hold_req;
        send(CMD_CLEAR, 5'd0);
        for (int i = 0; i < 8; i++)
            send(CMD_APPEND, 5'($urandom_range(0, 2)));
        send(CMD_FINISH, 5'd0);
        for (int i = 0; i < 5; i++)
            send(CMD_QUERY, 5'($urandom_range(0, 2)));
        send(CMD_END, 5'd0);
        send(CMD_READ, 5'd0);
        drain();
    endtask

    task automatic test_random(int total);
        int sent;
        int k;
        sent = 0;
        while (sent < total)
        begin
            no_idle = (sent > total / 3 && sent < total / 2);
            if ($urandom_range(0, 99) < 15)
            begin
                send(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
                sent++;
            end
            else
            begin
                k = ($urandom_range(0, 3) == 0) ? SYMBOLS : int'($urandom_range(2, 3));
                send(CMD_CLEAR, 5'd0);
                repeat ($urandom_range(1, 24))
                begin
                    if ($urandom_range(0, 40) == 0)
                        send(CMD_APPEND, 5'($urandom_range(26, 31)));
                    else
                        send(CMD_APPEND, 5'($urandom_range(0, k - 1)));
                    sent++;
                end
                send(CMD_FINISH, 5'd0);
                repeat ($urandom_range(1, 4))
                begin
                    repeat ($urandom_range(0, 12))
                    begin
                        if ($urandom_range(0, 30) == 0)
                            send(CMD_QUERY, 5'($urandom_range(0, 31)));
                        else
                            send(CMD_QUERY, 5'($urandom_range(0, k - 1)));
                        sent++;
                    end
                    send(CMD_END, 5'd0);
                    if ($urandom_range(0, 2) == 0)
                        send(CMD_READ, 5'd0);
                    sent += 2;
                end
                send(CMD_READ, 5'd0);
                sent += 3;
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        no_idle = 1'b0;
        sam_clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_capacity();
        test_random(280);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: suffix_automaton_common_substring.f
rtl/sac_pkg.sv
rtl/sac_core.sv
rtl/suffix_automaton_common_substring.sv
rtl/sac_checker.sv
verif/tb.sv
